>>> rtl/gol_pkg.sv
// ----------------------------------------------------------------------------
// Game of Life grid package
// Shared sizes, operation codes, register indexes and interface structs.
// ----------------------------------------------------------------------------
package gol_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  // Column and row index widths follow the grid maximum.
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  // Row counter holds a count up to the full height.
  localparam int CNT_W  = $clog2(MAX_HEIGHT + 1);
  // Size registers are seven bits wide.
  localparam int SIZE_W = 7;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Operation codes.
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  typedef logic [MAX_WIDTH-1:0] row_t;

  // Grid size in use, saturated to the maximum, and the mask of columns in use.
  typedef struct packed {
    logic [SIZE_W-1:0] used_w;
    logic [SIZE_W-1:0] used_h;
    row_t              col_mask;
  } gol_cfg_t;

  // One write port and one read port of the row store.
  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] waddr;
    row_t             wdata;
    logic             re;
    logic [ROW_W-1:0] raddr;
  } gol_mem_req_t;

endpackage

>>> rtl/life_cellular_automaton_grid_unit.sv
// ----------------------------------------------------------------------------
// Game of Life grid unit
// Grid of cells under rule B3/S23 with cell write, cell read and a
// whole-grid advance that sweeps the row store one row per cycle.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    op_i, col_i, row_i, alive_in_i
//   out      output     out_valid_o / out_stall_i  cell_value_o, range_error_o
//   cfg      input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A read or a write issues the row read in its accept cycle, picks out or patches the cell in
// the next, then hands the result to the output register. An item out of range, an unused
// code or an advance over an empty grid skips straight to the output. Any other advance loads
// the window, then sweeps the rows in use, paced by the single row store read port, which
// gives one old row per cycle. Reset clears the row valid bits, so the grid reads dead at once.
// A stalled result waits in the output register; only an item's final cycle waits behind it.
//
module life_cellular_automaton_grid_unit import gol_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Item input.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [COL_W-1:0]   col_i,
  input  logic [ROW_W-1:0]   row_i,
  input  logic               alive_in_i,
  // Result output.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               cell_value_o,
  output logic               range_error_o,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_WR    = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  gol_cfg_t     cfg;
  gol_mem_req_t mem_req;
  row_t         rd_data;
  row_t         next_row;
  row_t         below;
  row_t         patched;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             alive_q;
  row_t             above_q, mid_q;
  logic             pend_val_q, pend_err_q;
  logic             out_valid_q, cell_value_q, range_error_q;

  logic             in_acc;
  logic             in_range;
  logic             is_cell_op;
  logic             out_free;
  logic             last_row;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_inc2;

  gol_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gol_row_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  gol_row_rule u_rule (
    .above_i    (above_q),
    .mid_i      (mid_q),
    .below_i    (below),
    .col_mask_i (cfg.col_mask),
    .next_o     (next_row)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_cell_op = (op_i == OP_WRITE) || (op_i == OP_READ);
  assign in_range   = ({1'b0, col_i} < cfg.used_w) && ({1'b0, row_i} < cfg.used_h);
  assign out_free   = !out_valid_q || !out_stall_i;

  // The row below the one being swept is dead past the bottom of the grid.
  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign cnt_inc2 = cnt_q + CNT_W'(2);
  assign last_row = (SIZE_W'(cnt_inc) == cfg.used_h);
  assign below    = last_row ? '0 : rd_data;

  // A write replaces one cell of the row that was just read.
  always_comb begin
    patched        = rd_data;
    patched[col_q] = alive_q;
  end

  // Row store requests. A write back never meets a read of the same row:
  // the sweep reads two rows ahead of the row it writes, and a cell write
  // finishes before the next item is taken.
  always_comb begin
    mem_req = '0;
    case (state_q)
      S_IDLE: begin
        mem_req.re    = in_acc && ((is_cell_op && in_range)
                                   || ((op_i == OP_ADVANCE) && (cfg.used_h != '0)));
        mem_req.raddr = (op_i == OP_ADVANCE) ? '0 : row_i;
      end
      S_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = row_q;
        mem_req.wdata = patched;
      end
      S_FILL: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = ROW_W'(1);
      end
      S_SWEEP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_q[ROW_W-1:0];
        mem_req.wdata = next_row;
        mem_req.re    = !last_row;
        mem_req.raddr = cnt_inc2[ROW_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (is_cell_op && in_range) begin
            state_d = (op_i == OP_WRITE) ? S_WR : S_RD;
          end else if ((op_i == OP_ADVANCE) && (cfg.used_h != '0)) begin
            state_d = S_FILL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_RD:   state_d = S_DONE;
      S_WR:   state_d = S_DONE;
      S_FILL: begin
        cnt_d   = '0;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        cnt_d = cnt_inc;
        if (last_row) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item fields, the row window and the pending result.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          col_q      <= col_i;
          row_q      <= row_i;
          alive_q    <= alive_in_i;
          pend_val_q <= 1'b0;
          pend_err_q <= is_cell_op && !in_range;
        end
      end
      S_RD: pend_val_q <= rd_data[col_q];
      S_WR: pend_val_q <= alive_q;
      S_FILL: begin
        above_q <= '0;
        mid_q   <= rd_data;
      end
      S_SWEEP: begin
        above_q <= mid_q;
        mid_q   <= below;
      end
      default: ;
    endcase
    if ((state_q == S_DONE) && out_free) begin
      cell_value_q  <= pend_val_q;
      range_error_q <= pend_err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_value_o  = cell_value_q;
  assign range_error_o = range_error_q;

  // An advance over a non-empty grid always starts by loading the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op_i == OP_ADVANCE) && (cfg.used_h != '0)) |=> (state_q == S_FILL))
    else $error("advance did not start the row sweep");

  // The sweep never runs past the bottom row in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> (SIZE_W'(cnt_q) < cfg.used_h))
    else $error("row sweep ran past the grid height");

  // A flagged item never reports a live cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(range_error_o && cell_value_o))
    else $error("range error reported with a live cell value");

endmodule

>>> rtl/gol_cfg_regs.sv
// ----------------------------------------------------------------------------
// Game of Life grid configuration registers
// APB-style register file for the grid width and height.
// ----------------------------------------------------------------------------
module gol_cfg_regs import gol_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output gol_cfg_t           cfg_o
);

  logic [SIZE_W-1:0] grid_width_q;
  logic [SIZE_W-1:0] grid_height_q;
  logic              wr_en;
  logic              reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= SIZE_W'(MAX_WIDTH);
      grid_height_q <= SIZE_W'(MAX_HEIGHT);
    end else if (wr_en) begin
      case (reg_idx)
        REG_GRID_WIDTH:  grid_width_q  <= pwdata[SIZE_W-1:0];
        REG_GRID_HEIGHT: grid_height_q <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRID_WIDTH:  prdata = {{(PDATA_W-SIZE_W){1'b0}}, grid_width_q};
      REG_GRID_HEIGHT: prdata = {{(PDATA_W-SIZE_W){1'b0}}, grid_height_q};
      default:         prdata = '0;
    endcase
  end

  // Sizes above the maximum saturate.
  always_comb begin
    cfg_o.used_w = (grid_width_q > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH)
                                                       : grid_width_q;
    cfg_o.used_h = (grid_height_q > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT)
                                                         : grid_height_q;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      cfg_o.col_mask[i] = (SIZE_W'(i) < cfg_o.used_w);
    end
  end

endmodule

>>> rtl/gol_row_mem.sv
// ----------------------------------------------------------------------------
// Game of Life grid row store
// One row per entry, one write and one registered read per cycle. A row
// never written since reset reads as all dead.
// ----------------------------------------------------------------------------
module gol_row_mem import gol_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gol_mem_req_t req_i,
  output row_t         rd_data_o
);

  row_t                  mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_vld_q;
  row_t                  rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= row_vld_q[req_i.raddr] ? mem[req_i.raddr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (req_i.we) begin
      row_vld_q[req_i.waddr] <= 1'b1;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/gol_row_rule.sv
// ----------------------------------------------------------------------------
// Game of Life grid row rule
// Computes the next generation of one row from the old rows above, at and
// below it under rule B3/S23. Columns outside the mask are dead neighbors
// and keep their old value.
// ----------------------------------------------------------------------------
module gol_row_rule import gol_pkg::*; (
  input  row_t above_i,
  input  row_t mid_i,
  input  row_t below_i,
  input  row_t col_mask_i,
  output row_t next_o
);

  logic [MAX_WIDTH+1:0] a_pad;
  logic [MAX_WIDTH+1:0] m_pad;
  logic [MAX_WIDTH+1:0] b_pad;

  assign a_pad = {1'b0, above_i & col_mask_i, 1'b0};
  assign m_pad = {1'b0, mid_i   & col_mask_i, 1'b0};
  assign b_pad = {1'b0, below_i & col_mask_i, 1'b0};

  always_comb begin
    logic [3:0] n;
    for (int c = 0; c < MAX_WIDTH; c++) begin
      n = 4'(a_pad[c]) + 4'(a_pad[c+1]) + 4'(a_pad[c+2])
        + 4'(m_pad[c]) + 4'(m_pad[c+2])
        + 4'(b_pad[c]) + 4'(b_pad[c+1]) + 4'(b_pad[c+2]);
      if (!col_mask_i[c]) begin
        next_o[c] = mid_i[c];
      end else if (mid_i[c]) begin
        next_o[c] = (n == 4'd2) || (n == 4'd3);
      end else begin
        next_o[c] = (n == 4'd3);
      end
    end
  end

endmodule

>>> bench/life_cellular_automaton_grid_unit_tb.sv
// ----------------------------------------------------------------------------
// Game of Life grid unit testbench
// Drives cell writes, cell reads and generation advances through the item
// channel and resizes the grid through the register port. Every result is
// checked against its typed result or a cycle-free B3/S23 grid predictor
// in this file. A short table of directed items comes first, then random
// items under a series of grid sizes, with random idling on both sides.
// ----------------------------------------------------------------------------
module life_cellular_automaton_grid_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gol_pkg::*;

  // The item channel carries a two-bit code, so the fourth code is sent too.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Register addresses: one 32-bit register every four bytes.
  localparam logic [PADDR_W-1:0] ADDR_GRID_WIDTH  = {REG_GRID_WIDTH, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_GRID_HEIGHT = {REG_GRID_HEIGHT, 2'b00};

  localparam int RESET_CYCLES    = 10;
  localparam int IDLE_PCT        = 20;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES      = 10;
  localparam int SETTLE_CYCLES   = 8;
  localparam int END_CYCLES      = 80;
  localparam int HOLD_AT         = 250;
  localparam int HOLD_CYCLES     = 400;
  localparam int QUIET_FROM      = 500;
  localparam int QUIET_TO        = 700;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic cell_value;
    logic range_error;
  } cell_result_t;

  // One row of the directed table: either an item or a new grid size.
  typedef enum logic {ROW_ITEM, ROW_SIZE} step_kind_e;

  typedef struct packed {
    step_kind_e        kind;
    logic [1:0]        op;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              alive;
    logic [SIZE_W-1:0] size_w;
    logic [SIZE_W-1:0] size_h;
    logic              typed;
    cell_result_t      result;
  } step_t;

  localparam int DIRECTED_LEN = 28;

  // Columns: kind, op, col, row, alive, width, height, typed, expected result.
  // Rows without a typed result are checked against the predictor.
  localparam step_t DIRECTED [DIRECTED_LEN] = '{
    // A freshly reset grid reads dead at both corners.
    '{ROW_ITEM, OP_READ,    6'd0,  6'd0,  1'b0, 7'd0,   7'd0,   1'b1, 2'b00},
    '{ROW_ITEM, OP_READ,    6'd63, 6'd63, 1'b0, 7'd0,   7'd0,   1'b1, 2'b00},
    // A write returns the value written.
    '{ROW_ITEM, OP_WRITE,   6'd63, 6'd63, 1'b1, 7'd0,   7'd0,   1'b1, 2'b10},
    '{ROW_ITEM, OP_READ,    6'd63, 6'd63, 1'b0, 7'd0,   7'd0,   1'b0, 2'b00},
    '{ROW_ITEM, OP_WRITE,   6'd0,  6'd0,  1'b1, 7'd0,   7'd0,   1'b1, 2'b10},
    '{ROW_ITEM, OP_WRITE,   6'd0,  6'd0,  1'b0, 7'd0,   7'd0,   1'b1, 2'b00},
    // The unused code does nothing and flags nothing.
    '{ROW_ITEM, OP_UNUSED,  6'd63, 6'd63, 1'b1, 7'd0,   7'd0,   1'b1, 2'b00},
    // A vertical blinker on the top edge, then one advance.
    '{ROW_ITEM, OP_WRITE,   6'd1,  6'd0,  1'b1, 7'd0,   7'd0,   1'b1, 2'b10},
    '{ROW_ITEM, OP_WRITE,   6'd1,  6'd1,  1'b1, 7'd0,   7'd0,   1'b1, 2'b10},
    '{ROW_ITEM, OP_WRITE,   6'd1,  6'd2,  1'b1, 7'd0,   7'd0,   1'b1, 2'b10},
    '{ROW_ITEM, OP_ADVANCE, 6'd0,  6'd0,  1'b0, 7'd0,   7'd0,   1'b1, 2'b00},
    '{ROW_ITEM, OP_READ,    6'd0,  6'd1,  1'b0, 7'd0,   7'd0,   1'b0, 2'b00},
    '{ROW_ITEM, OP_READ,    6'd1,  6'd1,  1'b0, 7'd0,   7'd0,   1'b0, 2'b00},
    '{ROW_ITEM, OP_READ,    6'd2,  6'd1,  1'b0, 7'd0,   7'd0,   1'b0, 2'b00},
    '{ROW_ITEM, OP_READ,    6'd1,  6'd0,  1'b0, 7'd0,   7'd0,   1'b0, 2'b00},
    // The lone corner cell has no neighbors and must have died.
    '{ROW_ITEM, OP_READ,    6'd63, 6'd63, 1'b0, 7'd0,   7'd0,   1'b0, 2'b00},
    // A 3 by 3 grid: the first column and row outside it are flagged.
    '{ROW_SIZE, OP_WRITE,   6'd0,  6'd0,  1'b0, 7'd3,   7'd3,   1'b0, 2'b00},
    '{ROW_ITEM, OP_WRITE,   6'd3,  6'd0,  1'b1, 7'd0,   7'd0,   1'b1, 2'b01},
    '{ROW_ITEM, OP_READ,    6'd0,  6'd3,  1'b0, 7'd0,   7'd0,   1'b1, 2'b01},
    '{ROW_ITEM, OP_WRITE,   6'd2,  6'd2,  1'b1, 7'd0,   7'd0,   1'b0, 2'b00},
    '{ROW_ITEM, OP_ADVANCE, 6'd0,  6'd0,  1'b0, 7'd0,   7'd0,   1'b1, 2'b00},
    '{ROW_ITEM, OP_READ,    6'd2,  6'd2,  1'b0, 7'd0,   7'd0,   1'b0, 2'b00},
    // An empty grid flags every access, and an advance leaves it alone.
    '{ROW_SIZE, OP_WRITE,   6'd0,  6'd0,  1'b0, 7'd0,   7'd0,   1'b0, 2'b00},
    '{ROW_ITEM, OP_WRITE,   6'd0,  6'd0,  1'b1, 7'd0,   7'd0,   1'b1, 2'b01},
    '{ROW_ITEM, OP_ADVANCE, 6'd0,  6'd0,  1'b0, 7'd0,   7'd0,   1'b1, 2'b00},
    // Sizes above the maximum saturate to the full grid.
    '{ROW_SIZE, OP_WRITE,   6'd0,  6'd0,  1'b0, 7'd127, 7'd127, 1'b0, 2'b00},
    '{ROW_ITEM, OP_READ,    6'd1,  6'd1,  1'b0, 7'd0,   7'd0,   1'b0, 2'b00},
    '{ROW_ITEM, OP_WRITE,   6'd63, 6'd0,  1'b1, 7'd0,   7'd0,   1'b0, 2'b00}
  };

  // Grid sizes of the random phases; one last phase picks its size at random.
  localparam logic [SIZE_W-1:0] PHASE_W [NUM_PHASES] =
    '{7'd64, 7'd1, 7'd127, 7'd0, 7'd5, 7'd8, 7'd3,  7'd64, 7'd2, 7'd17};
  localparam logic [SIZE_W-1:0] PHASE_H [NUM_PHASES] =
    '{7'd64, 7'd1, 7'd127, 7'd5, 7'd0, 7'd8, 7'd64, 7'd3,  7'd9, 7'd40};

  // Block ports. Every input holds a known value from time zero.
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i          = OP_WRITE;
  logic [COL_W-1:0]   col_i         = '0;
  logic [ROW_W-1:0]   row_i         = '0;
  logic               alive_in_i    = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic               cell_value_o;
  logic               range_error_o;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [PADDR_W-1:0] paddr         = '0;
  logic [PDATA_W-1:0] pwdata        = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  life_cellular_automaton_grid_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .col_i         (col_i),
    .row_i         (row_i),
    .alive_in_i    (alive_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cell_value_o  (cell_value_o),
    .range_error_o (range_error_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the grid and the two size registers as last written.
  // --------------------------------------------------------------------------
  logic [MAX_WIDTH-1:0] grid_model [MAX_HEIGHT];
  logic [SIZE_W-1:0]    width_reg  = 7'd64;
  logic [SIZE_W-1:0]    height_reg = 7'd64;

  // Results still owed by the unit, oldest first.
  cell_result_t expected_cells [$];

  int mismatches  = 0;
  int items_in    = 0;
  int idle_cycles = 0;
  int n_writes    = 0;
  int n_reads     = 0;
  int n_advances  = 0;
  int n_unused    = 0;
  int n_results   = 0;
  int n_flagged   = 0;
  int n_sizes     = 0;

  function automatic int used_cols();
    return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
  endfunction

  function automatic int used_rows();
    return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
  endfunction

  // One generation over the grid in use. Every new cell is computed from a
  // snapshot of the old grid; neighbors outside the grid in use are dead,
  // and cells outside it keep their value.
  function automatic void advance_generation();
    logic [MAX_WIDTH-1:0] old_rows [MAX_HEIGHT];
    int w;
    int h;
    int n;
    w = used_cols();
    h = used_rows();
    old_rows = grid_model;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < h &&
                c + dc >= 0 && c + dc < w) begin
              n += int'(old_rows[r + dr][c + dc]);
            end
          end
        end
        grid_model[r][c] = old_rows[r][c] ? (n == 2 || n == 3) : (n == 3);
      end
    end
  endfunction

  // Applies one item to the predictor and returns the result it must cause.
  function automatic cell_result_t predict_cell(input logic [1:0] op,
                                                input logic [COL_W-1:0] col,
                                                input logic [ROW_W-1:0] row,
                                                input logic alive);
    cell_result_t res;
    res = '0;
    case (op)
      OP_WRITE, OP_READ: begin
        if (int'(col) < used_cols() && int'(row) < used_rows()) begin
          if (op == OP_WRITE) begin
            grid_model[row][col] = alive;
          end
          res.cell_value = grid_model[row][col];
        end else begin
          res.range_error = 1'b1;
        end
      end
      OP_ADVANCE: begin
        advance_generation();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void report_mismatch(input string what, input int exp_val,
                                          input int act_val);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, what,
               exp_val, act_val);
    end
  endfunction

  // The no-idle stretch is keyed to the number of items taken in so far.
  function automatic bit quiet_now();
    return items_in >= QUIET_FROM && items_in < QUIET_TO;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: every result taken by the receiver is matched against
  // the oldest expectation, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cell_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (range_error_o) begin
        n_flagged++;
      end
      if (expected_cells.size() == 0) begin
        report_mismatch("unexpected result, cell_value", -1, int'(cell_value_o));
      end else begin
        want = expected_cells.pop_front();
        if (cell_value_o !== want.cell_value) begin
          report_mismatch("cell_value", int'(want.cell_value), int'(cell_value_o));
        end
        if (range_error_o !== want.range_error) begin
          report_mismatch("range_error", int'(want.range_error),
                          int'(range_error_o));
        end
      end
    end
  end

  // Items taken in, counted on the edge so that every process sees one value.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      items_in <= items_in + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, a quiet stretch, and once a long hold-off while
  // the sender keeps offering items so that the unit fills and stalls.
  // --------------------------------------------------------------------------
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && items_in >= HOLD_AT) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet_now() && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a run of cycles with no handshake on any port means a hang.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pready) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender side.
  // --------------------------------------------------------------------------

  // Offers one item and holds it until taken, then records what it must give.
  // Valid stays high on return, so the caller either offers the next item in
  // the same step or lowers valid itself.
  task automatic send_item(input logic [1:0] op, input logic [COL_W-1:0] col,
                           input logic [ROW_W-1:0] row, input logic alive,
                           input logic typed, input cell_result_t typed_result);
    cell_result_t predicted;
    in_valid_i <= 1'b1;
    op_i       <= op;
    col_i      <= col;
    row_i      <= row;
    alive_in_i <= alive;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // The predictor always runs so that its grid follows the unit's, even
    // where the table already gives the result.
    predicted = predict_cell(op, col, row, alive);
    expected_cells.push_back(typed ? typed_result : predicted);
    case (op)
      OP_WRITE:   n_writes++;
      OP_READ:    n_reads++;
      OP_ADVANCE: n_advances++;
      default:    n_unused++;
    endcase
  endtask

  // Random gap after an item, skipped during the quiet stretch.
  task automatic sender_gap();
    if (!quiet_now() && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // One register access: the setup phase, then the access phase, which ends
  // at the edge where pready is seen high.
  task automatic apb_transfer(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    if (wr && addr == ADDR_GRID_WIDTH) begin
      width_reg = wdata[SIZE_W-1:0];
    end else if (wr && addr == ADDR_GRID_HEIGHT) begin
      height_reg = wdata[SIZE_W-1:0];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // The sender stops and waits for every owed result before a resize, so
  // the registers only ever change while the unit is idle. Both registers
  // are read back after the writes.
  task automatic set_grid_size(input logic [SIZE_W-1:0] w,
                               input logic [SIZE_W-1:0] h);
    logic [PDATA_W-1:0] rd;
    in_valid_i <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    apb_transfer(1'b1, ADDR_GRID_WIDTH, PDATA_W'(w), rd);
    apb_transfer(1'b1, ADDR_GRID_HEIGHT, PDATA_W'(h), rd);
    apb_transfer(1'b0, ADDR_GRID_WIDTH, '0, rd);
    if (rd !== PDATA_W'(w)) begin
      report_mismatch("grid_width readback", int'(w), int'(rd));
    end
    apb_transfer(1'b0, ADDR_GRID_HEIGHT, '0, rd);
    if (rd !== PDATA_W'(h)) begin
      report_mismatch("grid_height readback", int'(h), int'(rd));
    end
    n_sizes++;
  endtask

  // Mostly writes and reads inside the grid in use with advances mixed in,
  // so that patterns build up and evolve; a share of accesses lands anywhere
  // in the index range, and a few carry the unused code.
  task automatic send_random_item();
    int               pick;
    bit               wild;
    logic [1:0]       op;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             alive;
    pick = $urandom_range(0, 99);
    wild = $urandom_range(0, 99) < 10;
    if (pick < 42) begin
      op = OP_WRITE;
    end else if (pick < 74) begin
      op = OP_READ;
    end else if (pick < 88) begin
      op = OP_ADVANCE;
    end else if (pick < 93) begin
      op = OP_UNUSED;
    end else begin
      op   = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
      wild = 1'b1;
    end
    if (wild || used_cols() == 0) begin
      col = COL_W'($urandom_range(0, MAX_WIDTH - 1));
    end else begin
      col = COL_W'($urandom_range(0, used_cols() - 1));
    end
    if (wild || used_rows() == 0) begin
      row = ROW_W'($urandom_range(0, MAX_HEIGHT - 1));
    end else begin
      row = ROW_W'($urandom_range(0, used_rows() - 1));
    end
    alive = $urandom_range(0, 99) < 40;
    send_item(op, col, row, alive, 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, the directed table, the random phases, the drain.
  // --------------------------------------------------------------------------
  initial begin
    foreach (grid_model[r]) begin
      grid_model[r] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under the reset size of 64 by 64, with resizes inline.
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      if (DIRECTED[i].kind == ROW_SIZE) begin
        set_grid_size(DIRECTED[i].size_w, DIRECTED[i].size_h);
      end else begin
        send_item(DIRECTED[i].op, DIRECTED[i].col, DIRECTED[i].row,
                  DIRECTED[i].alive, DIRECTED[i].typed, DIRECTED[i].result);
        sender_gap();
      end
    end

    // Random phases; the last one takes a random size of its own.
    for (int p = 0; p <= NUM_PHASES; p++) begin
      if (p < NUM_PHASES) begin
        set_grid_size(PHASE_W[p], PHASE_H[p]);
      end else begin
        set_grid_size(SIZE_W'($urandom_range(0, 127)),
                      SIZE_W'($urandom_range(0, 127)));
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_random_item();
        sender_gap();
      end
    end

    in_valid_i <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);

    $display("Sent %0d writes, %0d reads, %0d advances and %0d unused codes",
             n_writes, n_reads, n_advances, n_unused);
    $display("over %0d grid sizes; %0d results checked, %0d of them range flags",
             n_sizes, n_results, n_flagged);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches,
               expected_cells.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/gol_pkg.sv
rtl/gol_cfg_regs.sv
rtl/gol_row_mem.sv
rtl/gol_row_rule.sv
rtl/life_cellular_automaton_grid_unit.sv
bench/life_cellular_automaton_grid_unit_tb.sv
